// ----- rtl/rtumf_pkg.sv -----
// Package for the ratio-test unique-match filter.
// Field widths, result action codes and register reset value.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rtumf_pkg;

   localparam int QUERY_BITS  = 12;
   localparam int TRAIN_BITS  = 10;
   localparam int SLOT_BITS   = 10;
   localparam int SLOT_COUNT  = 1024;
   localparam int COUNT_BITS  = 11;
   localparam int ACTION_BITS = 2;
   localparam int RATIO_BITS  = 9;

   localparam logic [RATIO_BITS-1:0] RATIO_RESET = 9'd179;

   localparam logic [ACTION_BITS-1:0] ACT_REJECT  = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_APPEND  = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_REPLACE = 2'd2;
   localparam logic [ACTION_BITS-1:0] ACT_KEEP    = 2'd3;

endpackage

`default_nettype wire

// ----- rtl/rtumf_if.sv -----
// Valid/ready channel interfaces for the ratio-test unique-match filter.
// Depends on rtumf_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rtumf_req_if #(
   parameter int DIST_BITS = 16
);
   logic                               valid;
   logic                               ready;
   logic                               start_set;
   logic [rtumf_pkg::QUERY_BITS-1:0]   query_index;
   logic [rtumf_pkg::TRAIN_BITS-1:0]   train_index;
   logic [DIST_BITS-1:0]               best_distance;
   logic [DIST_BITS-1:0]               second_distance;

   modport source (
      output valid, start_set, query_index, train_index, best_distance, second_distance,
      input  ready
   );
   modport sink (
      input  valid, start_set, query_index, train_index, best_distance, second_distance,
      output ready
   );
endinterface

interface rtumf_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [rtumf_pkg::ACTION_BITS-1:0]  action;
   logic [rtumf_pkg::SLOT_BITS-1:0]    slot;
   logic [rtumf_pkg::QUERY_BITS-1:0]   query_out;
   logic [rtumf_pkg::TRAIN_BITS-1:0]   train_out;
   logic [rtumf_pkg::COUNT_BITS-1:0]   pair_count;

   modport source (
      output valid, action, slot, query_out, train_out, pair_count,
      input  ready
   );
   modport sink (
      input  valid, action, slot, query_out, train_out, pair_count,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/ratio_test_unique_match_filter_unit.sv -----
// Ratio-test filter keeping one match per train descriptor.
// Depends on rtumf_pkg and the channel interfaces in rtumf_if.sv.
//
// Usage:
//  req carries one nearest-neighbour candidate per beat; rsp returns one
//  result per candidate, in order. csr_write_enable/csr_write_data load
//  the ratio threshold (Q8); write it only while the block is idle.
//  Timing: the candidate and the train-table read are registered on accept,
//  the slot-table read and ratio product in ST_SLOT, and the result register
//  loads at the commit from ST_DECIDE as req.ready returns: one item at a
//  time. Two dependent synchronous reads set this: the train table gives
//  the slot, then the slot table gives the stored train and query.
//  Entry validity comes from the pair count: an entry is live when its slot
//  lies below the count and the slot table points back at the same train
//  index. A start flag empties the table simply by zeroing the count.
//  Reset: count cleared, ratio back to 179; req.ready then stays low while
//  the train table is zeroed, all TABLE_DEPTH entries (at most 1024), so
//  a train index never seen reads back as empty.
//  Stall: a result holds in the output register; the next beat is still
//  taken and waits at its decision step until the result register frees.
`timescale 1ns / 1ps
`default_nettype none

module ratio_test_unique_match_filter_unit #(
   parameter int TRAIN_ENTRIES = 1024,
   parameter int DIST_BITS     = 16
) (
   input  wire                                 clock,
   input  wire                                 reset,
   rtumf_req_if.sink                           req,
   rtumf_rsp_if.source                         rsp,
   input  wire                                 csr_write_enable,
   input  wire [rtumf_pkg::RATIO_BITS-1:0]     csr_write_data
);

   localparam int TABLE_DEPTH = (TRAIN_ENTRIES < rtumf_pkg::SLOT_COUNT) ?
                                TRAIN_ENTRIES : rtumf_pkg::SLOT_COUNT;
   localparam int TIDX_BITS   = $clog2(TABLE_DEPTH);
   localparam int PROD_BITS   = DIST_BITS + rtumf_pkg::RATIO_BITS;
   localparam int QB          = rtumf_pkg::QUERY_BITS;
   localparam int TB          = rtumf_pkg::TRAIN_BITS;
   localparam int SB          = rtumf_pkg::SLOT_BITS;
   localparam int CB          = rtumf_pkg::COUNT_BITS;
   localparam int AB          = rtumf_pkg::ACTION_BITS;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SLOT   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;
   localparam logic [1:0] ST_CLEAR  = 2'd3;

   typedef struct packed {
      logic [DIST_BITS-1:0] best;
      logic [SB-1:0]        slot;
   } train_entry_type;

   typedef struct packed {
      logic [TB-1:0] train;
      logic [QB-1:0] query;
   } slot_entry_type;

   // memories: train-indexed and slot-indexed
   train_entry_type train_mem [TABLE_DEPTH];
   slot_entry_type  slot_mem  [rtumf_pkg::SLOT_COUNT];

   logic [1:0]                   state_ff, state_in;
   logic [TIDX_BITS-1:0]         clr_ff, clr_in;
   logic [rtumf_pkg::RATIO_BITS-1:0] ratio_ff;
   logic [CB-1:0]                count_ff, count_in;

   logic                         it_start_ff;
   logic [QB-1:0]                it_query_ff;
   logic [TB-1:0]                it_train_ff;
   logic [DIST_BITS-1:0]         it_best_ff;
   logic [DIST_BITS-1:0]         it_second_ff;

   train_entry_type              ta_rd_ff;
   slot_entry_type               sl_rd_ff;
   logic [PROD_BITS-1:0]         prod_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [AB-1:0]                rsp_action_ff, rsp_action_in;
   logic [SB-1:0]                rsp_slot_ff, rsp_slot_in;
   logic [QB-1:0]                rsp_query_ff, rsp_query_in;
   logic [TB-1:0]                rsp_train_ff, rsp_train_in;

   logic                         accept;
   logic                         commit;
   logic                         clearing;
   logic                         pass;
   logic                         in_range;
   logic                         hit;
   logic                         better;
   logic [CB-1:0]                count_eff;
   logic                         wr_en;
   logic [SB-1:0]                wr_slot;
   logic [TIDX_BITS-1:0]         t_addr;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign commit    = (state_ff == ST_DECIDE) && (!rsp_valid_ff || rsp.ready);
   assign clearing  = (state_ff == ST_CLEAR);
   assign t_addr    = it_train_ff[TIDX_BITS-1:0];

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.action     = rsp_action_ff;
   assign rsp.slot       = rsp_slot_ff;
   assign rsp.query_out  = rsp_query_ff;
   assign rsp.train_out  = rsp_train_ff;
   assign rsp.pair_count = count_ff;

   always_comb begin
      count_eff = it_start_ff ? '0 : count_ff;
      in_range  = (32'(it_train_ff) < 32'(TRAIN_ENTRIES));
      pass      = ({{(PROD_BITS-DIST_BITS-8){1'b0}}, it_best_ff, 8'd0} <= prod_ff) && in_range;
      // live entry: slot below count and slot points back at this train
      hit       = ({1'b0, ta_rd_ff.slot} < count_eff) && (sl_rd_ff.train == it_train_ff);
      better    = (it_best_ff < ta_rd_ff.best);

      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_action_in = rsp_action_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_query_in  = rsp_query_ff;
      rsp_train_in  = rsp_train_ff;
      wr_en         = 1'b0;
      wr_slot       = ta_rd_ff.slot;

      if (commit) begin
         rsp_valid_in = 1'b1;
         count_in     = count_eff;
         priority if (!pass) begin
            rsp_action_in = rtumf_pkg::ACT_REJECT;
            rsp_slot_in   = '0;
            rsp_query_in  = '0;
            rsp_train_in  = '0;
         end else if (!hit) begin
            wr_en         = 1'b1;
            wr_slot       = count_eff[SB-1:0];
            rsp_action_in = rtumf_pkg::ACT_APPEND;
            rsp_slot_in   = count_eff[SB-1:0];
            rsp_query_in  = it_query_ff;
            rsp_train_in  = it_train_ff;
            if (count_eff < CB'(rtumf_pkg::SLOT_COUNT)) begin
               count_in = count_eff + CB'(1);
            end
         end else if (better) begin
            wr_en         = 1'b1;
            rsp_action_in = rtumf_pkg::ACT_REPLACE;
            rsp_slot_in   = ta_rd_ff.slot;
            rsp_query_in  = it_query_ff;
            rsp_train_in  = it_train_ff;
         end else begin
            rsp_action_in = rtumf_pkg::ACT_KEEP;
            rsp_slot_in   = ta_rd_ff.slot;
            rsp_query_in  = sl_rd_ff.query;
            rsp_train_in  = it_train_ff;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_SLOT;
         end
         ST_SLOT: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (commit) state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            clr_in = clr_ff + TIDX_BITS'(1);
            if (clr_ff == TIDX_BITS'(TABLE_DEPTH - 1)) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         ratio_ff     <= rtumf_pkg::RATIO_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) ratio_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         it_start_ff  <= req.start_set;
         it_query_ff  <= req.query_index;
         it_train_ff  <= req.train_index;
         it_best_ff   <= req.best_distance;
         it_second_ff <= req.second_distance;
      end
      if (state_ff == ST_SLOT) begin
         prod_ff <= PROD_BITS'(ratio_ff) * PROD_BITS'(it_second_ff);
      end
      rsp_action_ff <= rsp_action_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_query_ff  <= rsp_query_in;
      rsp_train_ff  <= rsp_train_in;
   end

   // train table: zeroed after reset, read on accept, written at commit
   always_ff @(posedge clock) begin
      if (accept) begin
         ta_rd_ff <= train_mem[req.train_index[TIDX_BITS-1:0]];
      end
      if (clearing) begin
         train_mem[clr_ff] <= '0;
      end else if (wr_en) begin
         train_mem[t_addr] <= '{best: it_best_ff, slot: wr_slot};
      end
   end

   // slot table: read once the slot is known, written at commit
   always_ff @(posedge clock) begin
      if (state_ff == ST_SLOT) begin
         sl_rd_ff <= slot_mem[ta_rd_ff.slot];
      end
      if (wr_en) begin
         slot_mem[wr_slot] <= '{train: it_train_ff, query: it_query_ff};
      end
   end

endmodule

`default_nettype wire

// ----- tb/match_table_checker.sv -----
// Checker for the ratio-test unique-match filter: mirrors the per-train table,
// predicts each result beat and compares it field by field.
// Depends on rtumf_pkg and the channel interfaces in rtumf_if.sv.
`timescale 1ns / 1ps

module match_table_checker #(
   parameter int DIST_BITS = 16
) (
   input  wire                             clock,
   input  wire                             reset,
   rtumf_req_if                            req,
   rtumf_rsp_if                            rsp,
   input  wire                             csr_write_enable,
   input  wire [rtumf_pkg::RATIO_BITS-1:0] csr_write_data,
   output int                              mismatches,
   output int                              outstanding
);
   import rtumf_pkg::*;

   localparam int TRAINS = 1 << TRAIN_BITS;
   localparam int SCALED_BITS = DIST_BITS + RATIO_BITS;

   typedef struct packed {
      logic [ACTION_BITS-1:0] action;
      logic [SLOT_BITS-1:0]   slot;
      logic [QUERY_BITS-1:0]  query_out;
      logic [TRAIN_BITS-1:0]  train_out;
      logic [COUNT_BITS-1:0]  pair_count;
   } match_outcome_type;

   logic                   live       [TRAINS];
   logic [DIST_BITS-1:0]   best_seen  [TRAINS];
   logic [SLOT_BITS-1:0]   owned_slot [TRAINS];
   logic [QUERY_BITS-1:0]  slot_query [SLOT_COUNT];
   logic [COUNT_BITS-1:0]  pairs;
   logic [RATIO_BITS-1:0]  ratio;
   match_outcome_type      match_outcomes [$];
   int                     faults = 0;

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   function automatic match_outcome_type apply_candidate(
      input logic                  start,
      input logic [QUERY_BITS-1:0] q,
      input logic [TRAIN_BITS-1:0] t,
      input logic [DIST_BITS-1:0]  d1,
      input logic [DIST_BITS-1:0]  d2
   );
      match_outcome_type       o;
      logic [SCALED_BITS-1:0]  scaled_best;
      logic [SCALED_BITS-1:0]  scaled_second;
      o        = '0;
      o.action = ACT_REJECT;
      if (start) begin
         foreach (live[i]) live[i] = 1'b0;
         pairs = '0;
      end
      scaled_best   = {1'b0, d1, 8'h00};
      scaled_second = SCALED_BITS'(ratio) * SCALED_BITS'(d2);
      if (scaled_best <= scaled_second) begin
         o.train_out = t;
         if (!live[t]) begin
            o.action      = ACT_APPEND;
            o.slot        = pairs[SLOT_BITS-1:0];
            live[t]       = 1'b1;
            best_seen[t]  = d1;
            owned_slot[t] = o.slot;
            slot_query[o.slot] = q;
            if (pairs < SLOT_COUNT) pairs = pairs + COUNT_BITS'(1);
         end else begin
            o.slot = owned_slot[t];
            if (d1 < best_seen[t]) begin
               o.action     = ACT_REPLACE;
               best_seen[t] = d1;
               slot_query[o.slot] = q;
            end else begin
               o.action = ACT_KEEP;
            end
         end
         o.query_out = slot_query[o.slot];
      end
      o.pair_count = pairs;
      return o;
   endfunction

   function automatic void check_field(input string field, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         faults++;
      end
   endfunction

   always @(posedge clock) begin : watch
      match_outcome_type due;
      match_outcome_type fresh;
      if (reset) begin
         foreach (live[i]) live[i] = 1'b0;
         pairs = '0;
         ratio = RATIO_RESET;
         match_outcomes.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (match_outcomes.size() == 0) begin
               $error("result beat with no candidate outstanding");
               faults++;
            end else begin
               due = match_outcomes.pop_front();
               check_field("action",     due.action,     rsp.action);
               check_field("slot",       due.slot,       rsp.slot);
               check_field("query_out",  due.query_out,  rsp.query_out);
               check_field("train_out",  due.train_out,  rsp.train_out);
               check_field("pair_count", due.pair_count, rsp.pair_count);
            end
         end
         if (csr_write_enable) ratio = csr_write_data;
         if (req.valid && req.ready) begin
            fresh = apply_candidate(req.start_set, req.query_index,
               req.train_index, req.best_distance, req.second_distance);
            match_outcomes = {match_outcomes, fresh};
         end
      end
      // registered so the stimulus side always sees the count as of the last edge
      mismatches  <= faults;
      outstanding <= match_outcomes.size();
   end

endmodule

// ----- tb/ratio_test_unique_match_filter_unit_test.sv -----
// Top of the ratio-test unique-match filter bench: clock, reset, stimulus and verdict.
// Depends on rtumf_pkg, rtumf_if.sv, the filter unit and match_table_checker.
`timescale 1ns / 1ps

module ratio_test_unique_match_filter_unit_test;
   import rtumf_pkg::*;

   localparam int DIST_BITS    = 16;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_ITEMS = 1900;
   localparam int DRAIN_CYCLES = 12;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [RATIO_BITS-1:0] csr_write_data;
   bit                    idle_on;
   int unsigned           ratio_now;
   int                    beats_sent;
   int                    mismatches;
   int                    outstanding;

   rtumf_req_if #(.DIST_BITS(DIST_BITS)) req ();
   rtumf_rsp_if                          rsp ();

   ratio_test_unique_match_filter_unit #(
      .TRAIN_ENTRIES(1024),
      .DIST_BITS    (DIST_BITS)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req             (req),
      .rsp             (rsp),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   match_table_checker #(.DIST_BITS(DIST_BITS)) table_check (
      .clock           (clock),
      .reset           (reset),
      .req             (req),
      .rsp             (rsp),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .mismatches      (mismatches),
      .outstanding     (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   initial begin : rsp_stalls
      int hold;
      rsp.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 2) == 0) begin
            rsp.ready <= 1'b0;
            hold = gap_len() + 1;
            repeat (hold) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         hold = $urandom_range(1, 8);
         repeat (hold) @(posedge clock);
      end
   end

   task automatic present_candidate(input logic start, input logic [QUERY_BITS-1:0] q,
                                    input logic [TRAIN_BITS-1:0] t,
                                    input logic [DIST_BITS-1:0] d1,
                                    input logic [DIST_BITS-1:0] d2);
      int gap;
      gap = idle_on ? gap_len() : 0;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid           <= 1'b1;
      req.start_set       <= start;
      req.query_index     <= q;
      req.train_index     <= t;
      req.best_distance   <= d1;
      req.second_distance <= d2;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      beats_sent++;
   endtask

   // drain, then load the threshold while the block sits idle
   task automatic set_ratio(input int unsigned r);
      req.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      csr_write_enable <= 1'b1;
      csr_write_data   <= r[RATIO_BITS-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      ratio_now = r;
   endtask

   // mostly distances that pass the ratio test, some on the boundary, some arbitrary
   task automatic shape_distances(output logic [DIST_BITS-1:0] d1,
                                  output logic [DIST_BITS-1:0] d2);
      int          r;
      int unsigned lim;
      r   = $urandom_range(0, 99);
      d2  = (r < 25) ? DIST_BITS'($urandom_range(0, 40)) : DIST_BITS'($urandom);
      lim = (ratio_now * d2) >> 8;
      if (lim > 65535) lim = 65535;
      if (r < 80)
         d1 = DIST_BITS'($urandom_range(0, lim));
      else if (r < 90)
         d1 = (lim < 65535 && r[0]) ? DIST_BITS'(lim + 1) : DIST_BITS'(lim);
      else
         d1 = DIST_BITS'($urandom);
   endtask

   // a match list from a cleared table over a narrow train window; a little noise
   task automatic run_group(input int span, input int length);
      logic [TRAIN_BITS-1:0] base;
      logic [TRAIN_BITS-1:0] t;
      logic [DIST_BITS-1:0]  d1;
      logic [DIST_BITS-1:0]  d2;
      logic                  st;
      int                    k;
      base = TRAIN_BITS'($urandom);
      for (k = 0; k < length; k++) begin
         st = (k == 0);
         t  = base + TRAIN_BITS'($urandom_range(0, span - 1));
         if ($urandom_range(0, 19) == 0) begin
            st = ($urandom_range(0, 3) == 0);
            t  = TRAIN_BITS'($urandom);
            d1 = DIST_BITS'($urandom);
            d2 = DIST_BITS'($urandom);
         end else begin
            shape_distances(d1, d2);
         end
         present_candidate(st, QUERY_BITS'($urandom), t, d1, d2);
      end
   endtask

   // every train index once in shuffled order fills all slots, then hits on a full list
   task automatic sweep_all_trains();
      logic [TRAIN_BITS-1:0] order [1 << TRAIN_BITS];
      logic [TRAIN_BITS-1:0] swap;
      logic [DIST_BITS-1:0]  d1;
      logic [DIST_BITS-1:0]  d2;
      int unsigned           lim;
      int                    k;
      int                    j;
      foreach (order[i]) order[i] = TRAIN_BITS'(i);
      for (k = (1 << TRAIN_BITS) - 1; k > 0; k--) begin
         j        = $urandom_range(0, k);
         swap     = order[k];
         order[k] = order[j];
         order[j] = swap;
      end
      for (k = 0; k < (1 << TRAIN_BITS); k++) begin
         d2  = DIST_BITS'($urandom);
         lim = (ratio_now * d2) >> 8;
         if (lim > 65535) lim = 65535;
         d1 = DIST_BITS'($urandom_range(0, lim));
         present_candidate(k == 0, QUERY_BITS'($urandom), order[k], d1, d2);
      end
      for (k = 0; k < 40; k++) begin
         shape_distances(d1, d2);
         present_candidate(1'b0, QUERY_BITS'($urandom), TRAIN_BITS'($urandom), d1, d2);
      end
   endtask

   initial begin : stimulus
      int          random_start;
      int          phase;
      int unsigned pick;
      reset               <= 1'b1;
      req.valid           <= 1'b0;
      req.start_set       <= 1'b0;
      req.query_index     <= '0;
      req.train_index     <= '0;
      req.best_distance   <= '0;
      req.second_distance <= '0;
      csr_write_enable    <= 1'b0;
      csr_write_data      <= '0;
      ratio_now  = RATIO_RESET;
      idle_on    = 1'b1;
      beats_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset threshold: zero distances, boundary, equal distance, reject with start
      present_candidate(1'b1, 12'd0,   10'd0,    16'd0,     16'd0);
      present_candidate(1'b0, 12'hFFF, 10'd0,    16'd0,     16'd0);
      present_candidate(1'b0, 12'hFFF, 10'd1023, 16'd100,   16'd200);
      present_candidate(1'b0, 12'd5,   10'd1023, 16'd99,    16'd1000);
      present_candidate(1'b0, 12'd6,   10'd1023, 16'd99,    16'd2000);
      present_candidate(1'b0, 12'd7,   10'd1023, 16'hFFFF,  16'hFFFF);
      present_candidate(1'b0, 12'd8,   10'd512,  16'd179,   16'd256);
      present_candidate(1'b0, 12'd9,   10'd513,  16'd180,   16'd256);
      present_candidate(1'b0, 12'd10,  10'd514,  16'd1,     16'd0);
      present_candidate(1'b1, 12'd11,  10'd1023, 16'd0,     16'hFFFF);
      present_candidate(1'b0, 12'hAAA, 10'h155,  16'h5555,  16'hFFFF);
      present_candidate(1'b0, 12'h555, 10'h2AA,  16'h2AAA,  16'hAAAA);
      present_candidate(1'b1, 12'h123, 10'd7,    16'hFFFF,  16'd1);
      present_candidate(1'b0, 12'h124, 10'd7,    16'd0,     16'd1);
      set_ratio(511);
      present_candidate(1'b0, 12'hFFF, 10'h3FF,  16'hFFFF,  16'hFFFF);
      present_candidate(1'b0, 12'd1,   10'h3FF,  16'hFFFE,  16'hFFFF);
      set_ratio(0);
      present_candidate(1'b0, 12'd2,   10'h3FF,  16'd0,     16'hFFFF);
      present_candidate(1'b0, 12'd3,   10'd20,   16'd1,     16'hFFFF);
      present_candidate(1'b0, 12'd4,   10'd20,   16'd0,     16'd0);
      set_ratio(256);
      present_candidate(1'b0, 12'd5,   10'd21,   16'd300,   16'd300);
      present_candidate(1'b0, 12'd6,   10'd21,   16'd301,   16'd300);
      present_candidate(1'b0, 12'd7,   10'd21,   16'd299,   16'd299);

      random_start = beats_sent;
      phase        = 0;
      while (beats_sent - random_start < RANDOM_ITEMS) begin
         case (phase)
            0:       pick = RATIO_RESET;
            1:       pick = 511;
            2:       pick = 0;
            3:       pick = 1;
            4:       pick = 256;
            default: pick = $urandom_range(0, 511);
         endcase
         set_ratio(pick);
         if (phase == 1) begin
            idle_on = 1'b1;
            sweep_all_trains();
         end else begin
            repeat (4) begin
               idle_on = ($urandom_range(0, 3) != 0);
               run_group($urandom_range(1, 24), $urandom_range(5, 40));
            end
         end
         phase++;
      end

      idle_on    = 1'b1;
      req.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/rtumf_pkg.sv
rtl/rtumf_if.sv
rtl/ratio_test_unique_match_filter_unit.sv
tb/match_table_checker.sv
tb/ratio_test_unique_match_filter_unit_test.sv
